/* rtl/lmd_pkg.sv */
// ----------------------------------------------------------------------------
// lmd_pkg: shared constants and types for the led matrix scan driver
// panel geometry, frame bank sizing, pwm level patterns, bank write port
// ----------------------------------------------------------------------------
package lmd_pkg;

  // panel geometry (height is even: upper and lower halves scan together)
  localparam int PANEL_WIDTH  = 192;
  localparam int PANEL_HEIGHT = 32;
  localparam int PWM_PLANES   = 64;

  localparam int FRAME_SIZE   = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int SCAN_ROWS    = PANEL_HEIGHT / 2;
  localparam int BANK_DEPTH   = SCAN_ROWS * PANEL_WIDTH;

  // field widths fixed by the interface
  localparam int IDX_W        = 13;
  localparam int BYTE_W       = 8;
  localparam int LEVEL_W      = 4;
  localparam int PIXEL_W      = 3 * LEVEL_W;
  localparam int ROW_OUT_W    = 4;
  localparam int PLANE_W      = 6;

  // derived widths
  localparam int BANK_AW      = $clog2(BANK_DEPTH);
  localparam int SCAN_AW      = $clog2(BANK_DEPTH + 1);
  localparam int COL_W        = $clog2(PANEL_WIDTH + 1);
  localparam int ROW_W        = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // pwm pattern for mid levels, about two thirds on
  localparam logic [63:0] PATTERN_MID = 64'hDB6D_B6DB_6DB6_DB6D;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
    logic [PIXEL_W-1:0] data;
  } lmd_wr_t;

  // levels 0-3 off, 4-11 two-thirds pattern, 12-15 on
  function automatic logic level_bit(input logic [LEVEL_W-1:0] level,
                                     input logic [PLANE_W-1:0] plane);
    logic bit_val;
    unique case (level[LEVEL_W-1:LEVEL_W-2])
      2'b00:   bit_val = 1'b0;
      2'b11:   bit_val = 1'b1;
      default: bit_val = PATTERN_MID[plane];
    endcase
    return bit_val;
  endfunction

endpackage

/* rtl/led_matrix_scan_pwm_driver.sv */
// ----------------------------------------------------------------------------
// led_matrix_scan_pwm_driver: dual-scan rgb led matrix driver, 64-plane pwm
//
// input channel (in_valid / in_stall): a write item (in_func = 0) stores one
// pixel of the frame store, a tick item (in_func = 1) produces one output
// item. writes never produce output and leave the scan position alone.
// output channel (out_valid / out_stall): per column tick six colour bits
// for the upper and lower half with shift_strobe; after the last column of
// a row one latch item with latch_strobe, the row address and blank colour.
// scan order is plane, then row, then column.
// pipeline: a tick passes the frame bank read register, then the
// level-pattern lookup into the output register, before its item is valid.
// throughput: one item per cycle unless stalled, set by one bank read per tick.
// reset: all scan counters go to zero and a clearing pass writes black into
// both frame banks, one address per cycle over all BANK_DEPTH (3072)
// addresses, during which in_stall is high.
// stall: a held output keeps its value; the middle stage still takes one
// more tick, after that in_stall rises until the output is taken.
// ----------------------------------------------------------------------------
module led_matrix_scan_pwm_driver
  import lmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  logic [IDX_W-1:0]  in_pixel_index,
  input  logic [BYTE_W-1:0] in_pixel_low,
  input  logic [BYTE_W-1:0] in_pixel_high,

  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_red_upper,
  output logic              out_green_upper,
  output logic              out_blue_upper,
  output logic              out_red_lower,
  output logic              out_green_lower,
  output logic              out_blue_lower,
  output logic              out_shift_strobe,
  output logic              out_latch_strobe,
  output logic [ROW_OUT_W-1:0] out_row_address,
  output logic [PLANE_W-1:0] out_plane_index
);

  // ---------------------------------------------------------------- control
  logic               clr_r, clr_nxt;
  logic [BANK_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_latch_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [PLANE_W-1:0] s1_plane_r;

  logic               out_valid_r, out_valid_nxt;

  // scan position
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic [SCAN_AW-1:0] addr_r, addr_nxt;   // row * width + column, upper half

  logic out_adv, s1_adv, accept, tick, wr_item, col_tick;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_stall = clr_r || !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign tick     = accept && (in_func == FUNC_TICK);
  assign wr_item  = accept && (in_func == FUNC_WRITE);
  assign col_tick = (col_r != COL_W'(PANEL_WIDTH));

  // ------------------------------------------------------------ write path
  logic [IDX_W-1:0]   lower_idx;
  logic               in_range, to_lower;
  logic [PIXEL_W-1:0] wr_pixel;
  lmd_wr_t            wr_up, wr_dn;

  assign lower_idx = in_pixel_index - IDX_W'(BANK_DEPTH);
  assign in_range  = in_pixel_index < IDX_W'(FRAME_SIZE);
  assign to_lower  = in_pixel_index >= IDX_W'(BANK_DEPTH);
  // zero enable nibble stores black
  assign wr_pixel  = (in_pixel_high[BYTE_W-1:LEVEL_W] != '0)
                   ? {in_pixel_high[LEVEL_W-1:0], in_pixel_low}
                   : '0;

  always_comb begin
    if (clr_r) begin
      wr_up = '{en: 1'b1, addr: clr_cnt_r, data: '0};
      wr_dn = '{en: 1'b1, addr: clr_cnt_r, data: '0};
    end else begin
      wr_up = '{en: wr_item && in_range && !to_lower,
                addr: in_pixel_index[BANK_AW-1:0], data: wr_pixel};
      wr_dn = '{en: wr_item && in_range && to_lower,
                addr: lower_idx[BANK_AW-1:0], data: wr_pixel};
    end
  end

  // ------------------------------------------------------------ frame banks
  logic [PIXEL_W-1:0] pix_up, pix_dn;
  logic               rd_en;

  // the latch tick reads nothing
  assign rd_en = tick && col_tick;

  lmd_bank u_bank_up (
    .clk     (clk),
    .wr      (wr_up),
    .rd_en   (rd_en),
    .rd_addr (addr_r[BANK_AW-1:0]),
    .rd_data (pix_up)
  );

  lmd_bank u_bank_dn (
    .clk     (clk),
    .wr      (wr_dn),
    .rd_en   (rd_en),
    .rd_addr (addr_r[BANK_AW-1:0]),
    .rd_data (pix_dn)
  );

  // ---------------------------------------------------------- clearing pass
  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_r) begin
      if (clr_cnt_r == BANK_AW'(BANK_DEPTH - 1)) begin
        clr_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
    end
  end

  // --------------------------------------------------------- scan counters
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    plane_nxt = plane_r;
    addr_nxt  = addr_r;
    if (tick) begin
      if (col_tick) begin
        col_nxt  = col_r + 1'b1;
        addr_nxt = addr_r + 1'b1;
      end else begin
        // row end: address already points at the next row
        col_nxt = '0;
        if (row_r == ROW_W'(SCAN_ROWS - 1)) begin
          row_nxt  = '0;
          addr_nxt = '0;
          if (plane_r == PLANE_W'(PWM_PLANES - 1)) begin
            plane_nxt = '0;
          end else begin
            plane_nxt = plane_r + 1'b1;
          end
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------- pipeline valid
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      s1_valid_nxt = tick;
    end
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      plane_r     <= '0;
      addr_r      <= '0;
    end else begin
      clr_r       <= clr_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      plane_r     <= plane_nxt;
      addr_r      <= addr_nxt;
    end
  end

  // stage one payload: scan position snapshot beside the bank read
  always_ff @(posedge clk) begin
    if (tick) begin
      s1_latch_r <= !col_tick;
      s1_row_r   <= row_r;
      s1_plane_r <= plane_r;
    end
  end

  // ------------------------------------------------------- output register
  logic [2:0] up_bits, dn_bits;

  always_comb begin
    up_bits = '0;
    dn_bits = '0;
    if (!s1_latch_r) begin
      up_bits = {level_bit(pix_up[3*LEVEL_W-1:2*LEVEL_W], s1_plane_r),
                 level_bit(pix_up[2*LEVEL_W-1:LEVEL_W], s1_plane_r),
                 level_bit(pix_up[LEVEL_W-1:0], s1_plane_r)};
      dn_bits = {level_bit(pix_dn[3*LEVEL_W-1:2*LEVEL_W], s1_plane_r),
                 level_bit(pix_dn[2*LEVEL_W-1:LEVEL_W], s1_plane_r),
                 level_bit(pix_dn[LEVEL_W-1:0], s1_plane_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      {out_blue_upper, out_green_upper, out_red_upper} <= up_bits;
      {out_blue_lower, out_green_lower, out_red_lower} <= dn_bits;
      out_shift_strobe <= !s1_latch_r;
      out_latch_strobe <= s1_latch_r;
      out_row_address  <= ROW_OUT_W'(s1_row_r);
      out_plane_index  <= s1_plane_r;
    end
  end

  assign out_valid = out_valid_r;

  // ------------------------------------------------------------- assertions
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> in_stall)
    else $error("item accepted during clearing pass");

  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input accepted with pipeline full and output stalled");

  a_strobe_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_shift_strobe != out_latch_strobe))
    else $error("output item must be either shift or latch");

  a_latch_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_latch_strobe) |->
      !(out_red_upper || out_green_upper || out_blue_upper ||
        out_red_lower || out_green_lower || out_blue_lower))
    else $error("latch item carries colour");

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && !col_tick) |=> (col_r == '0))
    else $error("column counter did not wrap after latch");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(PANEL_WIDTH))
    else $error("column counter out of range");

endmodule

/* rtl/lmd_bank.sv */
// ----------------------------------------------------------------------------
// lmd_bank: one half of the frame store
// single write port, one registered read port with read enable
// ----------------------------------------------------------------------------
module lmd_bank
  import lmd_pkg::*;
(
  input  logic               clk,
  input  lmd_wr_t            wr,
  input  logic               rd_en,
  input  logic [BANK_AW-1:0] rd_addr,
  output logic [PIXEL_W-1:0] rd_data
);

  logic [PIXEL_W-1:0] mem [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds while no read is requested
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
